// ===== design/mfp_pkg.sv =====
`default_nettype none

package mfp_pkg;

  // Default sizes handed to the top level
  localparam int unsigned REGISTER_COUNT_DEF = 256;
  localparam int unsigned NUM_TIMERS_DEF     = 4;

  // Register offsets with side effects
  localparam logic [7:0] OFS_ENABLE  = 8'h09;
  localparam logic [7:0] OFS_PENDING = 8'h0D;
  localparam logic [7:0] OFS_INSERV  = 8'h11;
  localparam logic [7:0] OFS_MASK    = 8'h15;
  localparam logic [7:0] OFS_VECTOR  = 8'h17;
  localparam logic [7:0] OFS_CTRL_A  = 8'h19;
  localparam logic [7:0] OFS_CTRL_B  = 8'h1B;
  localparam logic [7:0] OFS_CTRL_CD = 8'h1D;
  localparam logic [7:0] OFS_DATA_A  = 8'h1F;

  localparam logic [7:0] VECTOR_RESET  = 8'h40;
  localparam logic [7:0] VEC_BASE_MASK = 8'hF0;
  localparam logic [7:0] MASK_RESET    = 8'hFF;
  localparam logic [8:0] TIMER_FULL    = 9'd256;

  // Operation codes carried by the kind field
  typedef enum logic [2:0] {
    K_RDBYTE = 3'd0,
    K_RDWORD = 3'd1,
    K_WRBYTE = 3'd2,
    K_WRWORD = 3'd3,
    K_CLOCK  = 3'd4,
    K_VECTOR = 3'd5,
    K_IACK   = 3'd6
  } kind_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd_idx1;
    logic rd_vec;
    logic cap_hi;
    logic cap_lo;
    logic wr_byte;
    logic wr_hi;
    logic wr_lo;
    logic tick;
    logic ack;
    logic vec_claim;
    logic ref_pend;
    logic ref_insv;
    logic emit;
  } mfp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    kind_t kind;
    logic  ticks_zero;
    logic  tick_last;
    logic  clr_last;
    logic  out_free;
  } mfp_stat_t;

  // Fold an 8-bit offset into the register file; the depth is at least a
  // quarter of the offset range, so three conditional subtracts suffice
  function automatic logic [7:0] reg_wrap(input logic [7:0] a, input int unsigned count);
    logic [8:0] v;
    v = {1'b0, a};
    for (int i = 0; i < 3; i++) begin
      if (v >= 9'(count)) begin
        v = v - 9'(count);
      end
    end
    return v[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/mfp_ram.sv =====
`default_nettype none

module mfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/mfp_ctrl.sv =====
`default_nettype none

module mfp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire mfp_pkg::mfp_stat_t stat,
  output      mfp_pkg::mfp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_EXEC     = 10'b00_0000_0100,
    S_READ1    = 10'b00_0000_1000,
    S_READ2    = 10'b00_0001_0000,
    S_WRLO     = 10'b00_0010_0000,
    S_TICK     = 10'b00_0100_0000,
    S_REF_PEND = 10'b00_1000_0000,
    S_REF_INSV = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Take a word only when no operation is in flight
  assign in_stall = (state != S_IDLE);

  // Step through one operation
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.kind)
          mfp_pkg::K_RDBYTE, mfp_pkg::K_RDWORD: begin
            // first byte address is the default read address
            state_next = S_READ1;
          end
          mfp_pkg::K_VECTOR: begin
            cmd.rd_vec    = 1'b1;
            cmd.vec_claim = 1'b1;
            state_next    = S_READ1;
          end
          mfp_pkg::K_WRBYTE: begin
            cmd.wr_byte = 1'b1;
            state_next  = S_REF_PEND;
          end
          mfp_pkg::K_WRWORD: begin
            cmd.wr_hi  = 1'b1;
            state_next = S_WRLO;
          end
          mfp_pkg::K_CLOCK: begin
            state_next = stat.ticks_zero ? S_DONE : S_TICK;
          end
          mfp_pkg::K_IACK: begin
            cmd.ack    = 1'b1;
            state_next = S_REF_PEND;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_READ1: begin
        cmd.cap_hi = 1'b1;
        if (stat.kind == mfp_pkg::K_RDWORD) begin
          cmd.rd_idx1 = 1'b1;
          state_next  = S_READ2;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ2: begin
        cmd.cap_lo = 1'b1;
        state_next = S_DONE;
      end
      S_WRLO: begin
        cmd.wr_lo  = 1'b1;
        state_next = S_DONE;
      end
      S_TICK: begin
        cmd.tick = 1'b1;
        if (stat.tick_last) begin
          state_next = S_REF_PEND;
        end
      end
      S_REF_PEND: begin
        cmd.ref_pend = 1'b1;
        state_next   = S_REF_INSV;
      end
      S_REF_INSV: begin
        cmd.ref_insv = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/mfp_datapath.sv =====
`default_nettype none

module mfp_datapath #(
  parameter int unsigned REGISTER_COUNT = mfp_pkg::REGISTER_COUNT_DEF,
  parameter int unsigned NUM_TIMERS     = mfp_pkg::NUM_TIMERS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mfp_pkg::mfp_cmd_t cmd,
  output      mfp_pkg::mfp_stat_t stat,
  input  wire logic [2:0]        kind,
  input  wire logic [7:0]        address,
  input  wire logic [15:0]       write_data,
  input  wire logic [7:0]        tick_count,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [15:0]       read_data,
  output      logic [7:0]        vector,
  output      logic              irq
);

  localparam int unsigned ADDR_W = $clog2(REGISTER_COUNT);

  // Latched word
  mfp_pkg::kind_t item_kind;
  logic [7:0]     item_addr;
  logic [15:0]    item_data;
  logic [7:0]     ticks_left;

  // Register file port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_q;
  logic [ADDR_W-1:0] clr_cnt;

  logic [7:0]        wrap0;
  logic [7:0]        wrap1;
  logic [ADDR_W-1:0] idx0;
  logic [ADDR_W-1:0] idx1;

  // Interrupt state
  logic [7:0] pending_bits;
  logic [7:0] in_service_bits;
  logic [7:0] enable_bits;
  logic [7:0] mask_bits;
  logic       irq_flag;
  logic [7:0] act;
  logic [7:0] act_low;
  logic [2:0] act_idx;

  // Timers
  logic [2:0] tick_phase;
  logic [2:0] phase_next;
  logic [8:0] reload      [NUM_TIMERS];
  logic [8:0] count       [NUM_TIMERS];
  logic [8:0] count_next  [NUM_TIMERS];
  logic [2:0] ctrl        [NUM_TIMERS];
  logic [7:0] tick_hits;

  logic [7:0] hi_byte;
  logic [7:0] lo_byte;
  logic [7:0] vec_res;
  logic [7:0] wv;

  assign wrap0 = mfp_pkg::reg_wrap(item_addr, REGISTER_COUNT);
  assign wrap1 = mfp_pkg::reg_wrap(item_addr + 8'd1, REGISTER_COUNT);
  assign idx0  = wrap0[ADDR_W-1:0];
  assign idx1  = wrap1[ADDR_W-1:0];
  assign wv    = item_data[7:0];

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_left <= '0;
    end else if (cmd.load) begin
      item_kind  <= mfp_pkg::kind_t'(kind);
      item_addr  <= address;
      item_data  <= write_data;
      ticks_left <= tick_count;
    end else if (cmd.tick) begin
      ticks_left <= ticks_left - 8'd1;
    end
  end

  // Sweep the register file to its reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // Select the write source
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx0;
    ram_wdata = wv;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = (clr_cnt == ADDR_W'(mfp_pkg::OFS_VECTOR)) ? mfp_pkg::VECTOR_RESET : 8'h00;
    end else if (cmd.wr_byte) begin
      ram_we = 1'b1;
    end else if (cmd.wr_hi) begin
      ram_we    = 1'b1;
      ram_wdata = item_data[15:8];
    end else if (cmd.wr_lo) begin
      ram_we    = 1'b1;
      ram_waddr = idx1;
    end else if (cmd.ref_pend) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(mfp_pkg::OFS_PENDING);
      ram_wdata = act;
    end else if (cmd.ref_insv) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(mfp_pkg::OFS_INSERV);
      ram_wdata = in_service_bits;
    end
  end

  // Select the read address
  always_comb begin
    if (cmd.rd_vec) begin
      ram_raddr = ADDR_W'(mfp_pkg::OFS_VECTOR);
    end else if (cmd.rd_idx1) begin
      ram_raddr = idx1;
    end else begin
      ram_raddr = idx0;
    end
  end

  mfp_ram #(
    .WIDTH (8),
    .DEPTH (REGISTER_COUNT)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Lowest active source
  assign act     = pending_bits & enable_bits & mask_bits;
  assign act_low = act & (~act + 8'd1);
  always_comb begin
    act_idx = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (act[b]) begin
        act_idx = 3'(b);
      end
    end
  end

  // Advance each timer on its share of the phase
  assign phase_next = tick_phase + 3'd1;
  always_comb begin
    tick_hits = '0;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      count_next[k] = count[k];
      if (((phase_next & 3'((1 << k) - 1)) == 3'd0) && (ctrl[k] != 3'd0)) begin
        if (count[k] <= 9'd1) begin
          tick_hits[k]  = 1'b1;
          count_next[k] = reload[k];
        end else begin
          count_next[k] = count[k] - 9'd1;
        end
      end
    end
  end

  // Timer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase <= '0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        reload[k] <= mfp_pkg::TIMER_FULL;
        count[k]  <= mfp_pkg::TIMER_FULL;
        ctrl[k]   <= '0;
      end
    end else if (cmd.tick) begin
      tick_phase <= phase_next;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        count[k] <= count_next[k];
      end
    end else if (cmd.wr_byte) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        if ((k == 0 && idx0 == ADDR_W'(mfp_pkg::OFS_CTRL_A)) ||
            (k == 1 && idx0 == ADDR_W'(mfp_pkg::OFS_CTRL_B)) ||
            (k == 3 && idx0 == ADDR_W'(mfp_pkg::OFS_CTRL_CD))) begin
          ctrl[k] <= wv[2:0];
        end
        if (k == 2 && idx0 == ADDR_W'(mfp_pkg::OFS_CTRL_CD)) begin
          ctrl[k] <= wv[6:4];
        end
        if (idx0 == ADDR_W'(mfp_pkg::OFS_DATA_A + 8'(2 * k))) begin
          // data zero stands for a full count
          reload[k] <= (wv == 8'h00) ? mfp_pkg::TIMER_FULL : {1'b0, wv};
          count[k]  <= (wv == 8'h00) ? mfp_pkg::TIMER_FULL : {1'b0, wv};
        end
      end
    end
  end

  // Interrupt controller registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits    <= '0;
      in_service_bits <= '0;
      enable_bits     <= '0;
      mask_bits       <= mfp_pkg::MASK_RESET;
      irq_flag        <= 1'b0;
    end else begin
      if (cmd.tick) begin
        pending_bits <= pending_bits | tick_hits;
      end
      if (cmd.ack) begin
        pending_bits    <= '0;
        in_service_bits <= '0;
      end
      if (cmd.vec_claim) begin
        in_service_bits <= in_service_bits | act_low;
      end
      if (cmd.wr_byte) begin
        if (idx0 == ADDR_W'(mfp_pkg::OFS_ENABLE)) begin
          enable_bits <= wv;
        end
        if (idx0 == ADDR_W'(mfp_pkg::OFS_MASK)) begin
          mask_bits <= wv;
        end
        if (idx0 == ADDR_W'(mfp_pkg::OFS_PENDING)) begin
          pending_bits <= pending_bits & ~wv;
        end
        if (idx0 == ADDR_W'(mfp_pkg::OFS_INSERV)) begin
          in_service_bits <= in_service_bits & ~wv;
        end
      end
      if (cmd.ref_pend) begin
        irq_flag <= (act != 8'h00);
      end
    end
  end

  // Capture read bytes and form the vector
  always_ff @(posedge clk) begin
    if (cmd.cap_hi) begin
      hi_byte <= ram_q;
      vec_res <= (ram_q & mfp_pkg::VEC_BASE_MASK) + {5'b0, act_idx};
    end
    if (cmd.cap_lo) begin
      lo_byte <= ram_q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (item_kind)
        mfp_pkg::K_RDBYTE: read_data <= {8'h00, hi_byte};
        mfp_pkg::K_RDWORD: read_data <= {hi_byte, lo_byte};
        default:           read_data <= 16'h0000;
      endcase
      vector <= (item_kind == mfp_pkg::K_VECTOR) ? vec_res : 8'h00;
      irq    <= irq_flag;
    end
  end

  // Report to the sequencer
  always_comb begin
    stat.kind       = item_kind;
    stat.ticks_zero = (ticks_left == 8'd0);
    stat.tick_last  = (ticks_left == 8'd1);
    stat.clr_last   = (clr_cnt == ADDR_W'(REGISTER_COUNT - 1));
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ===== design/multifunction_timer_interrupt_unit.sv =====
// Timer and interrupt unit with a byte register file, four down-counting
// timers and an eight-source interrupt controller.
// Input channel (in_valid/in_stall) carries one operation word: kind,
// address, write_data, tick_count. Output channel (out_valid/out_stall)
// returns one word per operation: read_data, vector, irq.
// A sequencer runs one operation at a time. Reads fetch one or two
// bytes, writes store one or two; byte write, acknowledge and a clock
// advance of one or more ticks then refresh the pending and in-service
// entries of the register file. The next word is taken in the cycle after
// out_valid rises; an operation waits to emit while the output holds a word.
// The clock advance steps the timers one tick per cycle, and every
// register file access goes through its single read and write port.
// After reset the register file is swept to its reset contents, one entry
// per cycle through all REGISTER_COUNT entries; in_stall stays high meanwhile.
// The finished word sits in an output register; a new operation is taken
// while it waits, and a stalled output holds its word until taken.
`default_nettype none

module multifunction_timer_interrupt_unit #(
  parameter int unsigned REGISTER_COUNT = mfp_pkg::REGISTER_COUNT_DEF,
  parameter int unsigned NUM_TIMERS     = mfp_pkg::NUM_TIMERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  address,
  input  wire logic [15:0] write_data,
  input  wire logic [7:0]  tick_count,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [15:0] read_data,
  output      logic [7:0]  vector,
  output      logic        irq
);

  mfp_pkg::mfp_cmd_t  cmd;
  mfp_pkg::mfp_stat_t stat;

  mfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfp_datapath #(
    .REGISTER_COUNT (REGISTER_COUNT),
    .NUM_TIMERS     (NUM_TIMERS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .address    (address),
    .write_data (write_data),
    .tick_count (tick_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .vector     (vector),
    .irq        (irq)
  );

endmodule

`default_nettype wire
